[rtl/core/ppd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared constants, types and helper functions of the packed permutation
// decoder: deck geometry, controller command and status bundles, FSM states.
// ----------------------------------------------------------------------------
package ppd_pkg;

  // Deck geometry
  localparam int DECK_SIZE  = 52;
  localparam int CARD_W     = 6;
  localparam int POS_W      = 6;
  localparam int RANK_W     = 6;
  localparam int REM_W      = $clog2(DECK_SIZE + 1);
  localparam int FW_W       = 3;
  localparam int BYTE_W     = 8;
  localparam int BCNT_W     = 4;

  // Select unit walks the mask one byte-wide chunk per cycle
  localparam int CHUNK_W    = 8;
  localparam int LO_W       = 3;
  localparam int CI_W       = CARD_W - LO_W;
  localparam int NCHUNK     = (DECK_SIZE + CHUNK_W - 1) / CHUNK_W;
  localparam int MASK_PAD_W = NCHUNK * CHUNK_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SEARCH,
    ST_EMIT
  } ppd_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // take the input byte
    logic shift;  // consume one stream bit
    logic step;   // one chunk of the index search
    logic emit;   // write a result, retire the selected index
  } ppd_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic bits_done;   // no stream bits left in the current byte
    logic finished;    // permutation complete
    logic field_done;  // the bit being shifted completes a rank field
    logic hit;         // search found the index this cycle
    logic flush_next;  // after this emit only a zero-width field remains
    logic out_free;    // output register can take a result
  } ppd_sts_t;

  // Field width for r remaining indices: ceil(log2(r)), capped at six
  function automatic logic [FW_W-1:0] width_for(logic [REM_W-1:0] r);
    logic [FW_W-1:0] w;
    w = FW_W'(6);
    for (int k = 6; k >= 0; k--) begin
      if ((1 << k) >= int'(r)) w = FW_W'(k);
    end
    return w;
  endfunction

  // Number of set bits in one chunk
  function automatic logic [BCNT_W-1:0] popcnt8(logic [CHUNK_W-1:0] v);
    logic [BCNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < CHUNK_W; i++) c = c + BCNT_W'(v[i]);
    return c;
  endfunction

  // Position of the n-th set bit of a chunk, counting from bit 0
  function automatic logic [LO_W-1:0] nth_set8(logic [CHUNK_W-1:0] v,
                                               logic [LO_W-1:0] n);
    logic [BCNT_W-1:0] seen;
    logic [LO_W-1:0]   pos;
    logic              found;
    seen  = '0;
    pos   = '0;
    found = 1'b0;
    for (int i = 0; i < CHUNK_W; i++) begin
      if (v[i] && !found) begin
        if (seen == BCNT_W'(n)) begin
          pos   = LO_W'(i);
          found = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

[rtl/core/ppd_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_select
// Finds the rank-th set bit of the availability mask, one 8-bit chunk per step
// cycle from index 0 upward. Rank is counted down by each chunk's popcount.
// ----------------------------------------------------------------------------
module ppd_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppd_pkg::RANK_W-1:0]    rank_i,
  input  logic                          step_i,
  input  logic [ppd_pkg::DECK_SIZE-1:0] mask_i,
  output logic                          hit_o,
  output logic [ppd_pkg::CARD_W-1:0]    sel_o
);
  import ppd_pkg::*;

  logic [RANK_W-1:0]     rank_q, rank_d;
  logic [CI_W-1:0]       ci_q, ci_d;
  logic [MASK_PAD_W-1:0] mask_pad;
  logic [CHUNK_W-1:0]    chunk;
  logic [BCNT_W-1:0]     cnt;

  // Current chunk of the zero-padded mask
  always_comb begin
    mask_pad = MASK_PAD_W'(mask_i);
    chunk    = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      if (ci_q == CI_W'(c)) chunk = mask_pad[c*CHUNK_W +: CHUNK_W];
    end
    cnt = popcnt8(chunk);
  end

  assign hit_o = rank_q < RANK_W'(cnt);
  assign sel_o = {ci_q, nth_set8(chunk, rank_q[LO_W-1:0])};

  // Search pointer and leftover rank
  always_comb begin
    rank_d = rank_q;
    ci_d   = ci_q;
    if (start_i) begin
      rank_d = rank_i;
      ci_d   = '0;
    end else if (step_i && !hit_o) begin
      rank_d = rank_q - RANK_W'(cnt);
      ci_d   = ci_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
      ci_q   <= '0;
    end else begin
      rank_q <= rank_d;
      ci_q   <= ci_d;
    end
  end

endmodule

[rtl/core/ppd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_datapath
// Stream bit shifter, rank accumulator, deck bookkeeping (mask, remaining
// count, fill position), index search unit and the output register.
// ----------------------------------------------------------------------------
module ppd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ppd_pkg::ppd_cmd_t           cmd_i,
  output ppd_pkg::ppd_sts_t           sts_o,
  input  logic [ppd_pkg::BYTE_W-1:0]  stream_byte_i,
  input  logic                        first_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ppd_pkg::CARD_W-1:0]  card_index_o,
  output logic [ppd_pkg::POS_W-1:0]   deck_position_o,
  output logic                        last_o,
  output logic                        bad_rank_o
);
  import ppd_pkg::*;

  localparam logic [DECK_SIZE-1:0] MASK_FULL = '1;

  logic [BYTE_W-1:0]    sh_q, sh_d;
  logic [BCNT_W-1:0]    left_q, left_d;
  logic [RANK_W-1:0]    acc_q, acc_d;
  logic [FW_W-1:0]      gath_q, gath_d;
  logic [FW_W-1:0]      width_q, width_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [POS_W-1:0]     fill_q, fill_d;
  logic                 fin_q, fin_d;
  logic [DECK_SIZE-1:0] mask_q, mask_d;
  logic                 bad_q, bad_d;
  logic [CARD_W-1:0]    sel_q;

  logic                 out_valid_q;
  logic [CARD_W-1:0]    card_q;
  logic [POS_W-1:0]     pos_q;
  logic                 last_q;
  logic                 badr_q;

  logic [RANK_W-1:0]    acc_nx;
  logic [FW_W:0]        gath_nx;
  logic                 field_done;
  logic                 bad_nx;
  logic                 sel_start;
  logic [RANK_W-1:0]    sel_rank;
  logic                 sel_hit;
  logic [CARD_W-1:0]    sel_idx;
  logic                 is_last;
  logic [REM_W-1:0]     rem_dec;

  // Next rank bit and field completion
  assign acc_nx     = {acc_q[RANK_W-2:0], sh_q[BYTE_W-1]};
  assign gath_nx    = {1'b0, gath_q} + 1'b1;
  assign field_done = gath_nx >= {1'b0, width_q};
  assign bad_nx     = REM_W'(acc_nx) >= rem_q;
  assign is_last    = rem_q <= REM_W'(1);
  assign rem_dec    = rem_q - 1'b1;

  // Search start: on a completed field, or for the trailing zero-width field
  assign sel_start = (cmd_i.shift && field_done) || (cmd_i.emit && sts_o.flush_next);
  assign sel_rank  = (cmd_i.shift && bad_nx) ? RANK_W'(rem_dec) :
                     cmd_i.shift ? acc_nx : '0;

  ppd_select u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sel_start),
    .rank_i (sel_rank),
    .step_i (cmd_i.step),
    .mask_i (mask_q),
    .hit_o  (sel_hit),
    .sel_o  (sel_idx)
  );

  // Status to the controller
  always_comb begin
    sts_o.bits_done  = left_q == '0;
    sts_o.finished   = fin_q;
    sts_o.field_done = field_done;
    sts_o.hit        = sel_hit;
    sts_o.flush_next = rem_q == REM_W'(2);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Decoder state update
  always_comb begin
    sh_d    = sh_q;
    left_d  = left_q;
    acc_d   = acc_q;
    gath_d  = gath_q;
    width_d = width_q;
    rem_d   = rem_q;
    fill_d  = fill_q;
    fin_d   = fin_q;
    mask_d  = mask_q;
    bad_d   = bad_q;
    if (cmd_i.load) begin
      if (first_byte_i) begin
        sh_d    = {stream_byte_i[0], {(BYTE_W-1){1'b0}}};
        left_d  = BCNT_W'(1);
        acc_d   = '0;
        gath_d  = '0;
        width_d = width_for(REM_W'(DECK_SIZE));
        rem_d   = REM_W'(DECK_SIZE);
        fill_d  = '0;
        fin_d   = 1'b0;
        mask_d  = MASK_FULL;
      end else begin
        sh_d    = stream_byte_i;
        left_d  = BCNT_W'(BYTE_W);
      end
    end
    if (cmd_i.shift) begin
      sh_d   = {sh_q[BYTE_W-2:0], 1'b0};
      left_d = left_q - 1'b1;
      acc_d  = acc_nx;
      gath_d = gath_nx[FW_W-1:0];
      if (field_done) bad_d = bad_nx;
    end
    if (cmd_i.emit) begin
      mask_d = mask_q & ~(DECK_SIZE'(1) << sel_q);
      acc_d  = '0;
      gath_d = '0;
      bad_d  = 1'b0;
      if (is_last) begin
        fin_d   = 1'b1;
        rem_d   = '0;
        width_d = '0;
      end else begin
        fill_d  = fill_q + 1'b1;
        rem_d   = rem_dec;
        width_d = width_for(rem_dec);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      acc_q   <= '0;
      gath_q  <= '0;
      width_q <= width_for(REM_W'(DECK_SIZE));
      rem_q   <= REM_W'(DECK_SIZE);
      fill_q  <= '0;
      fin_q   <= 1'b0;
      mask_q  <= MASK_FULL;
      bad_q   <= 1'b0;
    end else begin
      left_q  <= left_d;
      acc_q   <= acc_d;
      gath_q  <= gath_d;
      width_q <= width_d;
      rem_q   <= rem_d;
      fill_q  <= fill_d;
      fin_q   <= fin_d;
      mask_q  <= mask_d;
      bad_q   <= bad_d;
    end
  end

  // Byte shifter and found index: payload only
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    if (cmd_i.step && sel_hit) sel_q <= sel_idx;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      card_q <= sel_q;
      pos_q  <= fill_q;
      last_q <= is_last;
      badr_q <= bad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign card_index_o    = card_q;
  assign deck_position_o = pos_q;
  assign last_o          = last_q;
  assign bad_rank_o      = badr_q;

endmodule

[rtl/core/ppd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_ctrl
// Sequencer: takes a byte, shifts its bits one per cycle, runs the index
// search on each completed field and writes each result out.
// ----------------------------------------------------------------------------
module ppd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ppd_pkg::ppd_sts_t sts_i,
  output ppd_pkg::ppd_cmd_t cmd_o
);
  import ppd_pkg::*;

  ppd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts_i.bits_done || sts_i.finished) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.shift = 1'b1;
          if (sts_i.field_done) state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (sts_i.hit) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.flush_next ? ST_SEARCH : ST_SHIFT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/packed_permutation_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_permutation_decoder_core
// Unranks a packed byte stream into a permutation of deck indices.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with stream_byte_i and first_byte_i.
// A transfer with first_byte_i set restarts decoding and contributes only bit
// 0; other bytes contribute eight bits, MSB first. Output channel:
// out_valid_o / out_stall_i with card_index_o, deck_position_o, last_o and
// bad_rank_o; one byte yields zero to five result transfers.
// One byte is handled at a time: the input stalls from its transfer until
// all its bits are consumed or the permutation completes. Bits are shifted
// one per cycle; each completed field pauses the shifting for an index
// search (one 8-bit mask chunk per cycle) and the write of its result.
// A stalled output holds its result and the sequencer waits before writing
// the next one. Reset clears the mask to all available and starts at the
// first field of a fresh permutation, with no result pending.
// ----------------------------------------------------------------------------
module packed_permutation_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ppd_pkg::BYTE_W-1:0]  stream_byte_i,
  input  logic                        first_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ppd_pkg::CARD_W-1:0]  card_index_o,
  output logic [ppd_pkg::POS_W-1:0]   deck_position_o,
  output logic                        last_o,
  output logic                        bad_rank_o
);
  import ppd_pkg::*;

  ppd_cmd_t cmd;
  ppd_sts_t sts;

  ppd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ppd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .stream_byte_i  (stream_byte_i),
    .first_byte_i   (first_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .card_index_o   (card_index_o),
    .deck_position_o(deck_position_o),
    .last_o         (last_o),
    .bad_rank_o     (bad_rank_o)
  );

endmodule

[rtl/core/ppd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_checker
// Port-level checks of the decoder core, attached by bind.
// ----------------------------------------------------------------------------
module ppd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [ppd_pkg::CARD_W-1:0]  card_index_o,
  input logic [ppd_pkg::POS_W-1:0]   deck_position_o,
  input logic                        last_o,
  input logic                        bad_rank_o
);
  import ppd_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(card_index_o)
      && $stable(deck_position_o) && $stable(last_o) && $stable(bad_rank_o))
    else $error("stalled result changed");

  // A byte transfer keeps the core busy for at least the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on consecutive cycles");

  // Last flag marks exactly the final deck position
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_o == (deck_position_o == POS_W'(DECK_SIZE - 1)))
    else $error("last flag and deck position disagree");

  // Selected index lies inside the deck
  a_card: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> card_index_o < CARD_W'(DECK_SIZE))
    else $error("card index outside deck");

endmodule

bind packed_permutation_decoder_core ppd_checker u_ppd_checker (.*);

[sim/tb_packed_permutation_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_permutation_decoder_core
// Self-checking bench for the packed permutation decoder. Byte streams of
// packed rank fields go in. A behavioral unranker predicts the card,
// position, last and bad-rank flags of each result, and every output
// transfer is checked in order. Both channels see random gaps, and one long
// output hold-off backs the core up into its input.
// ----------------------------------------------------------------------------
module tb_packed_permutation_decoder_core;

  localparam int DECK        = ppd_pkg::DECK_SIZE;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int ITEM_TARGET = 330;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [ppd_pkg::CARD_W-1:0] card;
    logic [ppd_pkg::POS_W-1:0]  slot;
    logic                       last;
    logic                       bad;
  } dealt_card_t;

  // Behavioral unranker plus the queue of cards it expects to see dealt
  class deck_unranker;
    logic [ppd_pkg::DECK_SIZE-1:0] free_cards;
    logic [5:0]                    rank_bits;
    int unsigned                   bits_in;
    int unsigned                   width;
    int unsigned                   slot;
    int unsigned                   produced;
    int unsigned                   errors;
    bit                            complete;
    dealt_card_t                   dealt_cards[$];

    function new();
      errors = 0;
      restart_deck();
    endfunction

    // ceil(log2(left)), capped at six
    static function int unsigned field_bits(int unsigned left);
      int unsigned w;
      w = 0;
      while (w < 6 && (1 << w) < left) w++;
      return w;
    endfunction

    function void restart_deck();
      free_cards = '1;
      rank_bits  = '0;
      bits_in    = 0;
      slot       = 0;
      width      = field_bits(ppd_pkg::DECK_SIZE);
      complete   = 1'b0;
    endfunction

    // Take the rank-th free card; an out-of-range rank takes the highest one
    function void deal_card();
      int unsigned left;
      int unsigned rank;
      int unsigned sel;
      int unsigned seen;
      bit          bad;
      bit          found;
      dealt_card_t res;
      left  = ppd_pkg::DECK_SIZE - slot;
      rank  = rank_bits;
      bad   = (rank >= left);
      sel   = 0;
      seen  = 0;
      found = 1'b0;
      for (int i = 0; i < ppd_pkg::DECK_SIZE; i++) begin
        if (free_cards[i]) begin
          if (bad) begin
            sel   = i;
            found = 1'b1;
          end else if (!found) begin
            if (seen == rank) begin
              sel   = i;
              found = 1'b1;
            end
            seen++;
          end
        end
      end
      if (found) free_cards[sel] = 1'b0;
      res.card = ppd_pkg::CARD_W'(sel);
      res.slot = ppd_pkg::POS_W'(slot);
      res.last = (left <= 1);
      res.bad  = bad;
      dealt_cards.push_back(res);
      produced++;
      rank_bits = '0;
      bits_in   = 0;
      if (left <= 1) begin
        complete = 1'b1;
        width    = 0;
      end else begin
        slot++;
        width = field_bits(left - 1);
      end
    endfunction

    // The final field has no bits and completes at once
    function void flush_empty_fields();
      while (!complete && width == 0 && produced < 5) deal_card();
    endfunction

    // Note one accepted input byte
    function void take_byte(logic [7:0] data, logic restart);
      logic [7:0]  bits;
      int unsigned nbits;
      produced = 0;
      bits     = data;
      nbits    = 8;
      if (restart) begin
        restart_deck();
        bits  = {data[0], 7'b0};
        nbits = 1;
      end
      flush_empty_fields();
      for (int k = 0; k < nbits && !complete; k++) begin
        rank_bits = {rank_bits[4:0], bits[7-k]};
        bits_in++;
        if (bits_in >= width && produced < 5) begin
          deal_card();
          flush_empty_fields();
        end
      end
    endfunction

    // Check one output transfer against the oldest expected card
    function void check_card(logic [5:0] card, logic [5:0] slot_seen, logic last,
                             logic bad);
      dealt_card_t want;
      if (dealt_cards.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: card %0d position %0d last %0b bad %0b",
                   card, slot_seen, last, bad);
        return;
      end
      want = dealt_cards.pop_front();
      if (want.card !== card || want.slot !== slot_seen || want.last !== last ||
          want.bad !== bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected card %0d pos %0d last %0b bad %0b, got card %0d pos %0d last %0b bad %0b",
                   want.card, want.slot, want.last, want.bad,
                   card, slot_seen, last, bad);
      end
    endfunction

    function void close_out();
      if (dealt_cards.size() != 0) begin
        errors += dealt_cards.size();
        $display("%0d expected results never arrived", dealt_cards.size());
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i;
  logic        first_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [5:0]  card_index_o;
  logic [5:0]  deck_position_o;
  logic        last_o;
  logic        bad_rank_o;

  deck_unranker unranker;
  int unsigned  items_sent;
  int unsigned  bytes_taken;
  int unsigned  cycle_count;
  bit           steady;

  packed_permutation_decoder_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .stream_byte_i   (stream_byte_i),
    .first_byte_i    (first_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .card_index_o    (card_index_o),
    .deck_position_o (deck_position_o),
    .last_o          (last_o),
    .bad_rank_o      (bad_rank_o)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Timeout
  initial begin
    cycle_count = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_packed_permutation_decoder_core: done, errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Transfer monitor: inputs feed the unranker, outputs are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        bytes_taken++;
        unranker.take_byte(stream_byte_i, first_byte_i);
      end
      if (out_valid_o && !out_stall_i)
        unranker.check_card(card_index_o, deck_position_o, last_o, bad_rank_o);
    end
  end

  // Output side: alternating stall and open stretches, one long hold-off
  initial begin : receiver
    int unsigned span;
    bit          stalling;
    bit          held;
    span        = 0;
    stalling    = 1'b0;
    held        = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && bytes_taken >= 50) begin
        held        = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stalling = 1'b0;
        span     = 0;
      end
      if (span == 0) begin
        stalling = !stalling;
        if (stalling) span = idle_len();
        else span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 8);
        if (span == 0) begin
          stalling = 1'b0;
          span     = $urandom_range(1, 8);
        end
      end
      out_stall_i <= stalling;
      span--;
    end
  end

  // One input transfer, after an optional gap
  task automatic send_byte(input logic [7:0] data, input logic restart, input bit counts);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= data;
    first_byte_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    if (counts) items_sent++;
  endtask

  // Pack rank fields for a deck: first bit rides on the restart byte
  task automatic send_deck(input int unsigned fields, input bit trailing);
    bit          stream_bits[$];
    int unsigned left;
    int unsigned w;
    int unsigned rank;
    int unsigned pick;
    logic [7:0]  data;
    for (int f = 0; f < fields; f++) begin
      left = DECK - f;
      w    = deck_unranker::field_bits(left);
      pick = $urandom_range(0, 19);
      if (pick == 0) rank = 0;
      else if (pick == 1) rank = left - 1;
      else if (pick == 2 && (1 << w) > left) rank = $urandom_range(left, (1 << w) - 1);
      else rank = $urandom_range(0, left - 1);
      for (int k = w - 1; k >= 0; k--) stream_bits.push_back(rank[k]);
    end
    // pad the last byte with junk bits
    while (stream_bits.size() == 0 || (stream_bits.size() - 1) % 8 != 0)
      stream_bits.push_back($urandom_range(0, 1));
    send_byte({7'($urandom), stream_bits[0]}, 1'b1, 1'b1);
    for (int i = 1; i < stream_bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) data[7-k] = stream_bits[i+k];
      send_byte(data, 1'b0, 1'b1);
    end
    // bytes after a finished deck are dropped by the core
    if (trailing) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  // Raw random bytes, rare restarts
  task automatic send_noise(input int unsigned count);
    repeat (count) send_byte(8'($urandom), ($urandom_range(0, 15) == 0), 1'b1);
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    int unsigned mode;
    items_sent    = 0;
    bytes_taken   = 0;
    steady        = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    stream_byte_i = '0;
    first_byte_i  = 1'b0;
    unranker      = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes before any restart decode from the reset state
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b1);
    // restart with data bit one, then restart again mid-field with bit zero
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'hFE, 1'b1, 1'b1);
    // all-ones field: rank 63 is out of range
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    // rank 51 of 52 (highest legal), then rank 51 of 51 (just out of range)
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'h9E, 1'b0, 1'b1);
    send_byte(8'h60, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);

    // carry the open deck on unaligned so it ends with junk bits
    send_noise(40);
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      mode   = $urandom_range(0, 19);
      if (mode < 14) send_deck(DECK - 1, $urandom_range(0, 1));
      else if (mode < 17) send_deck($urandom_range(1, DECK - 2), 1'b0);
      else send_noise($urandom_range(4, 30));
    end
    in_valid_i <= 1'b0;

    // drain, then watch for stray results
    while (unranker.dealt_cards.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    unranker.close_out();
    if (unranker.errors == 0) begin
      $display("tb_packed_permutation_decoder_core: done, clean");
    end else begin
      $display("tb_packed_permutation_decoder_core: done, errors");
    end
    $finish;
  end

endmodule
